// File: rtl/core/mst_pkg.sv
// mst_pkg: shared types, codes and scaling constants of the multitouch slot tracker
// used by every module under rtl/core; depends on nothing

package mst_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_FIELD_W   = 6;
	localparam int QUEUE_DEPTH    = 2;

	localparam int COORD_W = 11;
	localparam int SPAN_W  = 10;
	localparam int FACT_W  = 32;
	localparam int PROD_W  = SPAN_W + FACT_W;

	localparam logic [4:0] TYPE_ABS   = 5'd3;
	localparam logic [9:0] CODE_SLOT  = 10'h02F;
	localparam logic [9:0] CODE_X     = 10'h035;
	localparam logic [9:0] CODE_Y     = 10'h036;
	localparam logic [9:0] CODE_TRACK = 10'h039;
	localparam logic [31:0] TRACK_NONE = '1;

	localparam int X_SPAN = 767;
	localparam int X_TOP  = 1403;
	localparam int Y_SPAN = 1023;
	localparam int Y_TOP  = 1871;

	// divide by span as multiply by rounded-up reciprocal; exact for products below 2^21
	localparam int RECIP_SHIFT = 31;
	localparam longint unsigned X_RECIP = ((64'd1 << RECIP_SHIFT) + X_SPAN - 1) / X_SPAN;
	localparam longint unsigned Y_RECIP = ((64'd1 << RECIP_SHIFT) + Y_SPAN - 1) / Y_SPAN;
	localparam logic [FACT_W-1:0] X_FACTOR = FACT_W'(X_RECIP * X_TOP);
	localparam logic [FACT_W-1:0] Y_FACTOR = FACT_W'(Y_RECIP * Y_TOP);

	typedef enum logic [2:0] {
		CMD_SELECT,
		CMD_SET_X,
		CMD_SET_Y,
		CMD_TRACK,
		CMD_POLL
	} cmd_kind_t;

	typedef enum logic [1:0] {
		TOUCH_NONE    = 2'd0,
		TOUCH_CLICK   = 2'd1,
		TOUCH_RELEASE = 2'd2
	} touch_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic        operation;
		logic [4:0]  event_type;
		logic [9:0]  event_code;
		logic signed [31:0] event_value;
	} item_t;

	typedef struct packed {
		touch_kind_t  touch_kind;
		logic [10:0]  touch_x;
		logic [10:0]  touch_y;
	} result_t;

	typedef struct packed {
		cmd_kind_t                kind;
		logic                     slot_ok;
		logic [SLOT_FIELD_W-1:0]  slot;
		logic [COORD_W-1:0]       coord;
		logic                     active;
	} cmd_t;

endpackage

// File: rtl/core/mst_front.sv
// mst_front: accepts event and poll words, drops inert events, scales coordinates
// depends on mst_pkg; feeds mst_queue with cmd_t words

module mst_front
	import mst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  push_valid,
	input  logic  push_ready,
	output cmd_t  push_cmd
);

	logic                    valid_s1;
	cmd_kind_t               kind_s1;
	logic                    slot_ok_s1;
	logic [SLOT_FIELD_W-1:0] slot_s1;
	logic                    active_s1;
	logic [SPAN_W-1:0]       span_s1;
	logic                    sat_s1;

	logic                    useful;
	cmd_kind_t               kind_d;
	logic [SPAN_W-1:0]       span_d;
	logic                    sat_d;
	logic [31:0]             val;
	logic [PROD_W-1:0]       prod;
	logic [COORD_W-1:0]      top;
	logic [FACT_W-1:0]       factor;

	assign val = item.event_value;

	always_comb begin
		useful = 1'b0;
		kind_d = CMD_POLL;
		span_d = '0;
		sat_d  = 1'b0;
		if (item.operation) begin
			useful = 1'b1;
		end else if (item.event_type == TYPE_ABS) begin
			case (item.event_code)
				CODE_SLOT: begin
					useful = 1'b1;
					kind_d = CMD_SELECT;
				end
				CODE_X: begin
					useful = 1'b1;
					kind_d = CMD_SET_X;
				end
				CODE_Y: begin
					useful = 1'b1;
					kind_d = CMD_SET_Y;
				end
				CODE_TRACK: begin
					useful = 1'b1;
					kind_d = CMD_TRACK;
				end
				default: useful = 1'b0;
			endcase
		end
		// negative raw saturates high, raw beyond span saturates to zero
		if (val[31]) begin
			sat_d = 1'b1;
		end else if (kind_d == CMD_SET_X) begin
			if (val[30:0] <= 31'(X_SPAN))
				span_d = SPAN_W'(X_SPAN) - val[SPAN_W-1:0];
		end else begin
			if (val[30:0] <= 31'(Y_SPAN))
				span_d = SPAN_W'(Y_SPAN) - val[SPAN_W-1:0];
		end
	end

	assign item_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid && useful;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready) begin
			kind_s1    <= kind_d;
			slot_ok_s1 <= !val[31] && (val[30:0] < 31'(SLOT_COUNT));
			slot_s1    <= val[SLOT_FIELD_W-1:0];
			active_s1  <= (val != TRACK_NONE);
			span_s1    <= span_d;
			sat_s1     <= sat_d;
		end
	end

	assign factor = (kind_s1 == CMD_SET_X) ? X_FACTOR : Y_FACTOR;
	assign top    = (kind_s1 == CMD_SET_X) ? COORD_W'(X_TOP) : COORD_W'(Y_TOP);
	assign prod   = PROD_W'(span_s1) * PROD_W'(factor);

	assign push_valid = valid_s1;

	always_comb begin
		push_cmd.kind    = kind_s1;
		push_cmd.slot_ok = slot_ok_s1;
		push_cmd.slot    = slot_s1;
		push_cmd.active  = active_s1;
		push_cmd.coord   = sat_s1 ? top : prod[RECIP_SHIFT +: COORD_W];
	end

endmodule

// File: rtl/core/mst_queue.sv
// mst_queue: short fifo of cmd_t words between front and back
// depends on mst_pkg

module mst_queue
	import mst_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: rtl/core/mst_back.sv
// mst_back: slot store, command execution and poll scan with result register
// depends on mst_pkg; takes cmd_t words from mst_queue

module mst_back
	import mst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pop_valid,
	output logic    pop_ready,
	input  cmd_t    pop_cmd,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	back_state_t state_q, state_d;

	logic [SLOT_W-1:0]     slot_index_q;
	logic                  slot_ok_q;
	logic [SLOT_COUNT-1:0] live_q;
	logic [SLOT_COUNT-1:0] rep_q;
	logic [SLOT_COUNT-1:0] xv_q;
	logic [SLOT_COUNT-1:0] yv_q;
	logic [COORD_W-1:0]    pos_x_mem [SLOT_COUNT];
	logic [COORD_W-1:0]    pos_y_mem [SLOT_COUNT];

	logic                  hit_q;
	logic [SLOT_W-1:0]     hit_idx_q;
	logic [COORD_W-1:0]    rd_x_q;
	logic [COORD_W-1:0]    rd_y_q;
	logic                  result_valid_q;
	result_t               result_q;

	logic [SLOT_COUNT-1:0] pending;
	logic                  hit;
	logic [SLOT_W-1:0]     hit_idx;
	logic                  exec;
	logic                  emit;
	logic                  wr_ok;

	assign pending = (live_q ^ rep_q) & xv_q & yv_q;

	// lowest pending slot wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (pending[i]) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		emit      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid && pop_cmd.kind == CMD_POLL)
					state_d = BK_SCAN;
			end
			BK_SCAN: state_d = BK_EMIT;
			BK_EMIT: begin
				if (!result_valid_q || result_ready) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign exec  = pop_valid && pop_ready;
	assign wr_ok = exec && slot_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_index_q   <= '0;
			slot_ok_q      <= 1'b1;
			live_q         <= '0;
			rep_q          <= '0;
			xv_q           <= '0;
			yv_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				case (pop_cmd.kind)
					CMD_SELECT: begin
						slot_ok_q <= pop_cmd.slot_ok;
						if (pop_cmd.slot_ok)
							slot_index_q <= pop_cmd.slot[SLOT_W-1:0];
					end
					CMD_SET_X: if (slot_ok_q) xv_q[slot_index_q] <= 1'b1;
					CMD_SET_Y: if (slot_ok_q) yv_q[slot_index_q] <= 1'b1;
					CMD_TRACK: if (slot_ok_q) live_q[slot_index_q] <= pop_cmd.active;
					default: ;
				endcase
			end
			if (emit && hit_q) begin
				if (live_q[hit_idx_q]) begin
					rep_q[hit_idx_q] <= 1'b1;
				end else begin
					rep_q[hit_idx_q] <= 1'b0;
					xv_q[hit_idx_q]  <= 1'b0;
					yv_q[hit_idx_q]  <= 1'b0;
				end
			end
			if (emit)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok && pop_cmd.kind == CMD_SET_X)
			pos_x_mem[slot_index_q] <= pop_cmd.coord;
		if (wr_ok && pop_cmd.kind == CMD_SET_Y)
			pos_y_mem[slot_index_q] <= pop_cmd.coord;
		if (state_q == BK_SCAN) begin
			hit_q     <= hit;
			hit_idx_q <= hit_idx;
			rd_x_q    <= pos_x_mem[hit_idx];
			rd_y_q    <= pos_y_mem[hit_idx];
		end
		if (emit) begin
			if (!hit_q) begin
				result_q.touch_kind <= TOUCH_NONE;
				result_q.touch_x    <= '0;
				result_q.touch_y    <= '0;
			end else begin
				result_q.touch_kind <= live_q[hit_idx_q] ? TOUCH_CLICK : TOUCH_RELEASE;
				result_q.touch_x    <= rd_x_q;
				result_q.touch_y    <= rd_y_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_scan_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |=> state_q == BK_EMIT)
		else $error("scan not followed by emit");

	a_reported_has_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_q & ~(xv_q & yv_q)) == '0)
		else $error("reported slot without both coordinates");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.touch_kind == TOUCH_NONE
		|-> result_q.touch_x == '0 && result_q.touch_y == '0)
		else $error("empty poll result carries coordinates");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_index_q <= SLOT_W'(SLOT_COUNT - 1))
		else $error("current slot out of range");

endmodule

// File: rtl/core/multitouch_slot_tracker.sv
// multitouch_slot_tracker: top level of the touch slot tracker
// depends on mst_pkg, mst_front, mst_queue, mst_back
//
// item channel (item_valid/item_ready/item): one word per input event or poll.
// an event word (operation 0) returns nothing; type 3 events select a slot,
// set a scaled X or Y, or set the tracking state of the current slot.
// a poll word (operation 1) returns exactly one word on the result channel
// (result_valid/result_ready/result): the lowest slot with a pending click or
// release, or touch_kind none with zero coordinates.
// event words are taken one per cycle unless the front stage holds a word that
// the full queue cannot take; the front stage holds the coordinate multiplier.
// a poll passes the back end in dispatch, slot scan with store read and result
// write, and the back end takes no new word from the queue until it is written.
// a stalled result holds the back end in its write step; the two-entry queue
// and the front stage keep accepting words until they fill.
// reset clears all slots to inactive, unreported and without coordinates,
// and selects slot 0.

module multitouch_slot_tracker
	import mst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	mst_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	mst_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	mst_back #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: test/tb.sv
// tb: self-checking testbench for multitouch_slot_tracker, directed touch sequences then random
// event and poll streams with random stalls on both channels; depends on mst_pkg and the rtl

module tb;
	import mst_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int ITEMS = 1750;
	localparam int LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_POLL  = 1'b1;

	typedef struct {
		item_t   w;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// tracker state as the stream leaves it
	logic [3:0]  cur_slot;
	logic        cur_ok;
	logic        slot_live [SLOTS];
	logic        slot_shown [SLOTS];
	logic [10:0] slot_x [SLOTS];
	logic        slot_x_ok [SLOTS];
	logic [10:0] slot_y [SLOTS];
	logic        slot_y_ok [SLOTS];

	result_t  pending_reports [$];
	dir_row_t dir_rows [$];
	int err_cnt = 0;
	int results_seen = 0;
	int words_counted = 0;
	int words_sent = 0;
	int cycle_cnt = 0;

	multitouch_slot_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("%0t: timeout, %0d reports still outstanding", $time, pending_reports.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [10:0] scale_coord(input int raw, input longint span,
			input longint top);
		longint q;
		q = ((span - longint'(raw)) * top) / span;
		if (q < 0)
			q = 0;
		if (q > top)
			q = top;
		return q[10:0];
	endfunction

	function automatic item_t mk(input logic op, input int typ, input int code, input int val);
		item_t w;
		w.operation = op;
		w.event_type = typ[4:0];
		w.event_code = code[9:0];
		w.event_value = val;
		return w;
	endfunction

	// mostly in the sensor range, sometimes just outside, sometimes anything
	function automatic int rand_raw(input int span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, span);
		if (r < 85)
			return $urandom_range(0, span + 3000) - 1500;
		return $urandom;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic reset_tracker;
		cur_slot = '0;
		cur_ok = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_shown[i] = 1'b0;
			slot_x[i] = '0;
			slot_x_ok[i] = 1'b0;
			slot_y[i] = '0;
			slot_y_ok[i] = 1'b0;
		end
	endtask

	// update tracker state for one word; a poll yields a report
	task automatic follow_word(input item_t w, output bit has_rep, output result_t rep);
		int v;
		bit found;
		v = w.event_value;
		has_rep = 1'b0;
		rep.touch_kind = TOUCH_NONE;
		rep.touch_x = '0;
		rep.touch_y = '0;
		if (w.operation == OP_EVENT) begin
			if (w.event_type != TYPE_ABS)
				return;
			if (w.event_code == CODE_SLOT) begin
				if (v >= 0 && v < SLOTS) begin
					cur_slot = v[3:0];
					cur_ok = 1'b1;
				end else begin
					cur_ok = 1'b0;
				end
				return;
			end
			if (!cur_ok)
				return;
			case (w.event_code)
				CODE_X: begin
					slot_x[cur_slot] = scale_coord(v, X_SPAN, X_TOP);
					slot_x_ok[cur_slot] = 1'b1;
				end
				CODE_Y: begin
					slot_y[cur_slot] = scale_coord(v, Y_SPAN, Y_TOP);
					slot_y_ok[cur_slot] = 1'b1;
				end
				CODE_TRACK: slot_live[cur_slot] = (w.event_value != TRACK_NONE);
				default: ;
			endcase
			return;
		end
		has_rep = 1'b1;
		found = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && slot_x_ok[i] && slot_y_ok[i] && slot_live[i] != slot_shown[i]) begin
				found = 1'b1;
				rep.touch_x = slot_x[i];
				rep.touch_y = slot_y[i];
				if (slot_live[i]) begin
					slot_shown[i] = 1'b1;
					rep.touch_kind = TOUCH_CLICK;
				end else begin
					slot_shown[i] = 1'b0;
					slot_x_ok[i] = 1'b0;
					slot_y_ok[i] = 1'b0;
					rep.touch_kind = TOUCH_RELEASE;
				end
			end
		end
	endtask

	// offer one word, hold it until taken, then log what it should produce
	task automatic send_word(input item_t w, input bit typed, input result_t want);
		int gap;
		bit has_rep;
		result_t rep;
		gap = pick_gap((words_sent % 400) >= 300);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		words_sent++;
		follow_word(w, has_rep, rep);
		if (has_rep)
			pending_reports.push_back(typed ? want : rep);
		if (w.operation == OP_POLL || (w.event_type == TYPE_ABS && (w.event_code == CODE_SLOT
				|| w.event_code == CODE_X || w.event_code == CODE_Y
				|| w.event_code == CODE_TRACK)))
			words_counted++;
	endtask

	task automatic add_row(input logic op, input int typ, input int code, input int val,
			input bit typed, input touch_kind_t kind, input int x, input int y);
		dir_row_t row;
		row.w = mk(op, typ, code, val);
		row.typed = typed;
		row.want.touch_kind = kind;
		row.want.touch_x = x[10:0];
		row.want.touch_y = y[10:0];
		dir_rows.push_back(row);
	endtask

	task automatic send_poll;
		send_word(mk(OP_POLL, $urandom, $urandom, $urandom), 1'b0, '0);
	endtask

	task automatic send_abs(input logic [9:0] code, input int val);
		send_word(mk(OP_EVENT, TYPE_ABS, code, val), 1'b0, '0);
	endtask

	// one finger going down or lifting on a mostly low slot
	task automatic send_touch_burst;
		int s;
		bit y_first;
		s = ($urandom_range(0, 3) < 3) ? $urandom_range(0, 3) : $urandom_range(0, SLOTS - 1);
		send_abs(CODE_SLOT, s);
		if ($urandom_range(0, 1)) begin
			y_first = $urandom_range(0, 1);
			if (y_first && $urandom_range(0, 99) < 85)
				send_abs(CODE_Y, rand_raw(Y_SPAN));
			if ($urandom_range(0, 99) < 85)
				send_abs(CODE_X, rand_raw(X_SPAN));
			if (!y_first && $urandom_range(0, 99) < 85)
				send_abs(CODE_Y, rand_raw(Y_SPAN));
			if ($urandom_range(0, 99) < 80)
				send_abs(CODE_TRACK, $urandom_range(0, 65535));
		end else begin
			send_abs(CODE_TRACK, TRACK_NONE);
		end
		if ($urandom_range(0, 99) < 60)
			send_poll();
	endtask

	task automatic send_single_event;
		int r;
		int val;
		r = $urandom_range(0, 3);
		case (r)
			0: begin
				case ($urandom_range(0, 4))
					0: val = -1;
					1: val = SLOTS;
					2: val = $urandom;
					3: val = $urandom_range(SLOTS, 63);
					default: val = $urandom_range(0, SLOTS - 1);
				endcase
				send_abs(CODE_SLOT, val);
			end
			1: send_abs(CODE_X, rand_raw(X_SPAN));
			2: send_abs(CODE_Y, rand_raw(Y_SPAN));
			default: send_abs(CODE_TRACK, $urandom_range(0, 1) ? int'(TRACK_NONE) : int'($urandom));
		endcase
	endtask

	// receiver: random stalls, calm stretches, and one long hold to back the block up
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		result_ready = 1'b0;
		forever begin
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap((cycle_cnt % 1000) < 200);
				if (gap == 0) begin
					result_ready <= 1'b1;
					@(posedge clk);
				end else begin
					result_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : report_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_reports.size() == 0) begin
				$display("%0t: result word with none expected: kind %0d x %0d y %0d", $time,
					result.touch_kind, result.touch_x, result.touch_y);
				err_cnt++;
			end else begin
				want = pending_reports.pop_front();
				if (result.touch_kind !== want.touch_kind) begin
					$display("%0t: touch_kind expected %0d got %0d", $time,
						want.touch_kind, result.touch_kind);
					err_cnt++;
				end
				if (result.touch_x !== want.touch_x) begin
					$display("%0t: touch_x expected %0d got %0d", $time,
						want.touch_x, result.touch_x);
					err_cnt++;
				end
				if (result.touch_y !== want.touch_y) begin
					$display("%0t: touch_y expected %0d got %0d", $time,
						want.touch_y, result.touch_y);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		int r;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		reset_tracker();

		add_row(OP_POLL, 0, 0, 0, 1, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_SLOT, 0, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_X, X_SPAN, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_Y, Y_SPAN, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_TRACK, 7, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 0, 0, 0, 1, TOUCH_CLICK, 0, 0);
		// a new id on a live slot is not a fresh touch
		add_row(OP_EVENT, TYPE_ABS, CODE_TRACK, 9, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 31, 1023, -1, 1, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_TRACK, TRACK_NONE, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 0, 0, 0, 1, TOUCH_RELEASE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_SLOT, 3, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_X, 0, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_Y, 32'h8000_0000, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_TRACK, 1, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 0, 0, 0, 1, TOUCH_CLICK, X_TOP, Y_TOP);
		// bad slot: later per-slot events are dropped
		add_row(OP_EVENT, TYPE_ABS, CODE_SLOT, -1, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_TRACK, TRACK_NONE, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 0, 0, 0, 1, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_SLOT, SLOTS, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, 31, CODE_SLOT, 15, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, 10'h3FF, -1, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_SLOT, SLOTS - 1, 0, TOUCH_NONE, 0, 0);
		// live slot without coordinates is skipped by the scan
		add_row(OP_EVENT, TYPE_ABS, CODE_TRACK, 32'h7FFF_FFFF, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 0, 0, 0, 1, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_X, 32'h7FFF_FFFF, 0, TOUCH_NONE, 0, 0);
		add_row(OP_EVENT, TYPE_ABS, CODE_Y, 700, 0, TOUCH_NONE, 0, 0);
		add_row(OP_POLL, 0, 0, 0, 0, TOUCH_NONE, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

		while (words_counted < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_touch_burst();
			else if (r < 75)
				send_poll();
			else if (r < 90)
				send_single_event();
			else
				send_word(mk(OP_EVENT, $urandom, $urandom, $urandom), 1'b0, '0);
		end
		item_valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/mst_pkg.sv
rtl/core/mst_front.sv
rtl/core/mst_queue.sv
rtl/core/mst_back.sv
rtl/core/multitouch_slot_tracker.sv
test/tb.sv
